// ----- rtl/dfhg_pkg.sv -----
package dfhg_pkg;

  // Largest number of frames one datagram may be split into.
  localparam int MAX_FRAGMENTS = 64;

  // Fragment header sizes in bytes.
  localparam logic [6:0] FIRST_HDR_BYTES = 7'd4;
  localparam logic [6:0] NEXT_HDR_BYTES  = 7'd5;

  // Dispatch patterns for the two fragment header types.
  localparam logic [7:0] DISPATCH_FIRST = 8'hC0;
  localparam logic [7:0] DISPATCH_NEXT  = 8'hE0;

  // Frame payload lengths are kept in whole 8-byte units.
  localparam logic [6:0] UNIT_MASK = 7'h78;

  typedef enum logic [1:0] {
    KIND_WHOLE = 2'd0,
    KIND_FIRST = 2'd1,
    KIND_NEXT  = 2'd2,
    KIND_DROP  = 2'd3
  } frame_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_EMIT
  } state_t;

  // Decision on one datagram, taken before any result is sent.
  typedef struct packed {
    frame_kind_t kind;
    logic [6:0]  whole_len;
    logic [6:0]  first_len;
    logic [6:0]  next_cap;
    logic [10:0] rest;
  } plan_t;

  // Running position of the fragment sequencer.
  typedef struct packed {
    logic [10:0] rest;
    logic [6:0]  next_cap;
    logic [11:0] pos;
    logic [10:0] ofs;
  } frag_pos_t;

  // One subsequent fragment and the position after it.
  typedef struct packed {
    logic [6:0]  len;
    logic        done;
    frag_pos_t   next;
  } frag_step_t;

endpackage

// ----- rtl/dfhg_plan.sv -----
module dfhg_plan (
  input  logic [6:0]      header_length,
  input  logic [10:0]     payload_length,
  input  logic [6:0]      frame_capacity,
  output dfhg_pkg::plan_t plan
);

  logic [11:0] total_len;
  logic [7:0]  first_need;
  logic [6:0]  next_raw;
  logic [6:0]  next_cap;
  logic [6:0]  first_raw;
  logic [6:0]  first_len;
  logic [10:0] rest;
  logic [12:0] rest_limit;
  logic        fits;
  logic        no_room;
  logic        too_many;

  // Room left in the first and the subsequent frames, in whole units.
  always_comb begin
    total_len  = {5'd0, header_length} + {1'b0, payload_length};
    fits       = total_len <= {5'd0, frame_capacity};
    first_need = {1'b0, header_length} + {1'b0, dfhg_pkg::FIRST_HDR_BYTES};
    next_raw   = frame_capacity - dfhg_pkg::NEXT_HDR_BYTES;
    next_cap   = next_raw & dfhg_pkg::UNIT_MASK;
    first_raw  = frame_capacity - dfhg_pkg::FIRST_HDR_BYTES - header_length;
    first_len  = first_raw & dfhg_pkg::UNIT_MASK;
    no_room    = (first_need > {1'b0, frame_capacity}) ||
                 (frame_capacity < dfhg_pkg::NEXT_HDR_BYTES) ||
                 (next_cap == 7'd0);
    rest       = payload_length - {4'd0, first_len};
    // More fragments than allowed exactly when the rest exceeds what the
    // remaining frames can carry.
    rest_limit = {6'd0, next_cap} * 13'(dfhg_pkg::MAX_FRAGMENTS - 1);
    too_many   = {2'd0, rest} > rest_limit;
  end

  // Classification of the datagram.
  always_comb begin
    plan.whole_len = total_len[6:0];
    plan.first_len = first_len;
    plan.next_cap  = next_cap;
    plan.rest      = rest;
    if (fits) begin
      plan.kind = dfhg_pkg::KIND_WHOLE;
    end else if (no_room || too_many) begin
      plan.kind = dfhg_pkg::KIND_DROP;
    end else begin
      plan.kind = dfhg_pkg::KIND_FIRST;
    end
  end

endmodule

// ----- rtl/dfhg_step.sv -----
module dfhg_step (
  input  dfhg_pkg::frag_pos_t  cur,
  output dfhg_pkg::frag_step_t step
);

  logic [6:0] len;

  // Shared unit: take as much of the rest as one frame carries and advance.
  always_comb begin
    if (cur.rest < {4'd0, cur.next_cap}) begin
      len = cur.rest[6:0];
    end else begin
      len = cur.next_cap;
    end
    step.len           = len;
    step.next.rest     = cur.rest - {4'd0, len};
    step.next.next_cap = cur.next_cap;
    step.next.pos      = cur.pos + {5'd0, len};
    step.next.ofs      = cur.ofs + {4'd0, len};
    step.done          = step.next.rest == 11'd0;
  end

endmodule

// ----- rtl/datagram_fragment_header_generator_core.sv -----
// Fragment header generator: each input beat describes one compressed
// datagram and yields either one unfragmented or drop descriptor, or a first
// fragment descriptor followed by subsequent fragment descriptors with the
// offset in 8-byte units; the tag counter advances once per fragmented
// datagram and wraps. The block takes one datagram at a time: after the input
// beat is captured, ST_PLAN loads the first (or only) descriptor and then
// ST_EMIT loads one subsequent fragment descriptor at a time, each load
// waiting while out_stall holds a result. The per-fragment step is one shared
// subtract-and-advance unit driven by the sequencer. A new input beat is
// taken only once the last descriptor of the previous datagram has been
// loaded into the output register.
module datagram_fragment_header_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_datagram_size,
  input  logic [10:0] in_start_offset,
  input  logic [6:0]  in_header_length,
  input  logic [10:0] in_payload_length,
  input  logic [6:0]  in_frame_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_frame_kind,
  output logic [7:0]  out_dispatch_byte,
  output logic [7:0]  out_size_low_byte,
  output logic [15:0] out_datagram_tag,
  output logic [7:0]  out_offset_units,
  output logic [11:0] out_data_start,
  output logic [6:0]  out_data_length,
  output logic        out_last
);

  dfhg_pkg::state_t     state_r, state_nxt;
  dfhg_pkg::plan_t      plan;
  dfhg_pkg::frag_pos_t  pos_r, pos_nxt;
  dfhg_pkg::frag_step_t step;

  logic [10:0] size_r;
  logic [10:0] start_r;
  logic [6:0]  hlen_r;
  logic [10:0] plen_r;
  logic [6:0]  cap_r;
  logic [15:0] tag_r, tag_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;
  logic        load_out;
  logic        take_in;

  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  disp_r, disp_nxt;
  logic [7:0]  szlo_r, szlo_nxt;
  logic [15:0] otag_r, otag_nxt;
  logic [7:0]  ofsu_r, ofsu_nxt;
  logic [11:0] dstart_r, dstart_nxt;
  logic [6:0]  dlen_r, dlen_nxt;
  logic        last_r, last_nxt;

  dfhg_plan u_plan (
    .header_length  (hlen_r),
    .payload_length (plen_r),
    .frame_capacity (cap_r),
    .plan           (plan)
  );

  dfhg_step u_step (
    .cur  (pos_r),
    .step (step)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != dfhg_pkg::ST_IDLE;
  assign take_in   = in_valid && !in_stall;

  // Sequencer: next state, output register load and running position.
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    tag_nxt    = tag_r;
    load_out   = 1'b0;
    kind_nxt   = kind_r;
    disp_nxt   = disp_r;
    szlo_nxt   = szlo_r;
    otag_nxt   = otag_r;
    ofsu_nxt   = ofsu_r;
    dstart_nxt = dstart_r;
    dlen_nxt   = dlen_r;
    last_nxt   = last_r;
    unique case (state_r)
      dfhg_pkg::ST_IDLE: begin
        if (take_in) begin
          state_nxt = dfhg_pkg::ST_PLAN;
        end
      end
      dfhg_pkg::ST_PLAN: begin
        if (slot_free) begin
          load_out   = 1'b1;
          kind_nxt   = plan.kind;
          disp_nxt   = 8'd0;
          szlo_nxt   = 8'd0;
          otag_nxt   = 16'd0;
          ofsu_nxt   = 8'd0;
          dstart_nxt = 12'd0;
          dlen_nxt   = 7'd0;
          last_nxt   = 1'b1;
          case (plan.kind)
            dfhg_pkg::KIND_WHOLE: begin
              dlen_nxt  = plan.whole_len;
              state_nxt = dfhg_pkg::ST_IDLE;
            end
            dfhg_pkg::KIND_FIRST: begin
              disp_nxt          = dfhg_pkg::DISPATCH_FIRST | {5'd0, size_r[10:8]};
              szlo_nxt          = size_r[7:0];
              otag_nxt          = tag_r;
              dlen_nxt          = hlen_r + plan.first_len;
              last_nxt          = 1'b0;
              tag_nxt           = tag_r + 16'd1;
              pos_nxt.rest      = plan.rest;
              pos_nxt.next_cap  = plan.next_cap;
              pos_nxt.pos       = {5'd0, hlen_r} + {5'd0, plan.first_len};
              pos_nxt.ofs       = start_r + {4'd0, plan.first_len};
              state_nxt         = dfhg_pkg::ST_EMIT;
            end
            default: begin
              state_nxt = dfhg_pkg::ST_IDLE;
            end
          endcase
        end
      end
      dfhg_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_out   = 1'b1;
          kind_nxt   = dfhg_pkg::KIND_NEXT;
          disp_nxt   = dfhg_pkg::DISPATCH_NEXT | {5'd0, size_r[10:8]};
          ofsu_nxt   = pos_r.ofs[10:3];
          dstart_nxt = pos_r.pos;
          dlen_nxt   = step.len;
          last_nxt   = step.done;
          pos_nxt    = step.next;
          if (step.done) begin
            state_nxt = dfhg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = dfhg_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfhg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tag_r       <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r       <= tag_nxt;
    end
  end

  // Captured input beat and running fragment position.
  always_ff @(posedge clk) begin
    if (take_in) begin
      size_r  <= in_datagram_size;
      start_r <= in_start_offset;
      hlen_r  <= in_header_length;
      plen_r  <= in_payload_length;
      cap_r   <= in_frame_capacity;
    end
    pos_r <= pos_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    disp_r   <= disp_nxt;
    szlo_r   <= szlo_nxt;
    otag_r   <= otag_nxt;
    ofsu_r   <= ofsu_nxt;
    dstart_r <= dstart_nxt;
    dlen_r   <= dlen_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_frame_kind    = kind_r;
  assign out_dispatch_byte = disp_r;
  assign out_size_low_byte = szlo_r;
  assign out_datagram_tag  = otag_r;
  assign out_offset_units  = ofsu_r;
  assign out_data_start    = dstart_r;
  assign out_data_length   = dlen_r;
  assign out_last          = last_r;

endmodule

// ----- dv/tb_datagram_fragment_header_generator_core.sv -----
`timescale 1ns / 100ps

module tb_datagram_fragment_header_generator_core;

  localparam int UNIT_BYTES = 8;
  // Smallest frame that leaves a whole 8-byte unit after a subsequent header.
  localparam int MIN_SPLIT_CAPACITY = dfhg_pkg::NEXT_HDR_BYTES + UNIT_BYTES;
  localparam int DRAIN_CYCLES = 32;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // Traffic pacing: which side idles, and how often.
  typedef enum int {
    RX_SLOW,
    TX_SLOW,
    NO_IDLE
  } pace_t;

  // Kinds of randomly built datagram.
  typedef enum int {
    SHAPE_ANY,
    SHAPE_WHOLE,
    SHAPE_SHORT,
    SHAPE_LONG
  } shape_t;

  typedef struct {
    logic [10:0] datagram_size;
    logic [10:0] start_offset;
    logic [6:0]  header_length;
    logic [10:0] payload_length;
    logic [6:0]  frame_capacity;
    pace_t       pace;
    bit          drain;
  } datagram_t;

  typedef struct packed {
    dfhg_pkg::frame_kind_t kind;
    logic [7:0]  dispatch;
    logic [7:0]  size_low;
    logic [15:0] tag;
    logic [7:0]  offset_units;
    logic [11:0] data_start;
    logic [6:0]  data_length;
    logic        last;
  } descriptor_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_datagram_size = '0;
  logic [10:0] in_start_offset = '0;
  logic [6:0]  in_header_length = '0;
  logic [10:0] in_payload_length = '0;
  logic [6:0]  in_frame_capacity = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_frame_kind;
  logic [7:0]  out_dispatch_byte;
  logic [7:0]  out_size_low_byte;
  logic [15:0] out_datagram_tag;
  logic [7:0]  out_offset_units;
  logic [11:0] out_data_start;
  logic [6:0]  out_data_length;
  logic        out_last;

  datagram_t   datagram_backlog[$];
  descriptor_t pending_descriptors[$];
  datagram_t   head;
  descriptor_t want;
  pace_t       pace = RX_SLOW;
  bit          offer;
  logic [15:0] next_tag = '0;
  int          total_datagrams;
  int          accepted_count = 0;
  int          frames_checked = 0;
  int          mismatch_count = 0;
  int          whole_count = 0;
  int          split_count = 0;
  int          drop_count = 0;
  int unsigned cycle_count = 0;

  datagram_fragment_header_generator_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_datagram_size  (in_datagram_size),
    .in_start_offset   (in_start_offset),
    .in_header_length  (in_header_length),
    .in_payload_length (in_payload_length),
    .in_frame_capacity (in_frame_capacity),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_kind    (out_frame_kind),
    .out_dispatch_byte (out_dispatch_byte),
    .out_size_low_byte (out_size_low_byte),
    .out_datagram_tag  (out_datagram_tag),
    .out_offset_units  (out_offset_units),
    .out_data_start    (out_data_start),
    .out_data_length   (out_data_length),
    .out_last          (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Percentage of cycles that a side spends idle under a given pacing.
  function automatic int idle_percent(pace_t p, bit receiver);
    case (p)
      RX_SLOW: return receiver ? 87 : 28;
      TX_SLOW: return receiver ? 28 : 87;
      default: return 0;
    endcase
  endfunction

  // Work out the frame descriptors that one datagram should be split into.
  function automatic void split_datagram(input logic [10:0] size, input logic [10:0] start_ofs,
                                         input logic [6:0] hlen, input logic [10:0] plen,
                                         input logic [6:0] cap);
    int unsigned hdr, body, room, next_room, first_body, rest, frames, ofs, pos, step;
    bit          fits;
    descriptor_t d;
    hdr = hlen;
    body = plen;
    room = cap;
    d = '0;
    d.last = 1'b1;
    // Header and payload fit one frame: send it whole.
    if (hdr + body <= room) begin
      d.kind = dfhg_pkg::KIND_WHOLE;
      d.data_length = 7'(hdr + body);
      pending_descriptors.push_back(d);
      whole_count++;
      return;
    end
    // The first frame must hold the header, and later frames a whole unit.
    fits = (hdr + dfhg_pkg::FIRST_HDR_BYTES <= room) && (room >= dfhg_pkg::NEXT_HDR_BYTES);
    next_room = 0;
    first_body = 0;
    rest = 0;
    if (fits) begin
      next_room = (room - dfhg_pkg::NEXT_HDR_BYTES) / UNIT_BYTES * UNIT_BYTES;
      first_body = (room - dfhg_pkg::FIRST_HDR_BYTES - hdr) / UNIT_BYTES * UNIT_BYTES;
      fits = next_room != 0;
    end
    if (fits) begin
      rest = body - first_body;
      frames = 1 + (rest + next_room - 1) / next_room;
      fits = frames <= dfhg_pkg::MAX_FRAGMENTS;
    end
    if (!fits) begin
      d.kind = dfhg_pkg::KIND_DROP;
      pending_descriptors.push_back(d);
      drop_count++;
      return;
    end
    // First fragment carries the header and a whole number of units.
    d.kind = dfhg_pkg::KIND_FIRST;
    d.dispatch = dfhg_pkg::DISPATCH_FIRST | {5'b0, size[10:8]};
    d.size_low = size[7:0];
    d.tag = next_tag;
    d.data_length = 7'(hdr + first_body);
    d.last = 1'b0;
    pending_descriptors.push_back(d);
    next_tag++;
    split_count++;
    // Subsequent fragments until the payload is used up.
    pos = hdr + first_body;
    ofs = start_ofs + first_body;
    d.kind = dfhg_pkg::KIND_NEXT;
    d.dispatch = dfhg_pkg::DISPATCH_NEXT | {5'b0, size[10:8]};
    while (rest > 0) begin
      step = rest < next_room ? rest : next_room;
      rest -= step;
      d.offset_units = 8'(ofs / UNIT_BYTES);
      d.data_start = 12'(pos);
      d.data_length = 7'(step);
      d.last = rest == 0;
      pending_descriptors.push_back(d);
      pos += step;
      ofs += step;
    end
  endfunction

  // Build a random datagram; the split shapes are always within the fragment limit.
  function automatic datagram_t make_datagram(shape_t shape, pace_t p, bit drain);
    datagram_t   g;
    int unsigned room, hdr, next_room, first_body, lo, hi;
    g.datagram_size = 11'($urandom_range(0, 2047));
    g.start_offset = 11'($urandom_range(0, 2047));
    g.pace = p;
    g.drain = drain;
    case (shape)
      SHAPE_ANY: begin
        g.header_length = 7'($urandom_range(0, 127));
        g.payload_length = 11'($urandom_range(0, 2047));
        g.frame_capacity = 7'($urandom_range(0, 127));
      end
      SHAPE_WHOLE: begin
        room = $urandom_range(0, 127);
        hdr = $urandom_range(0, room);
        g.header_length = 7'(hdr);
        g.payload_length = 11'($urandom_range(0, room - hdr));
        g.frame_capacity = 7'(room);
      end
      default: begin
        room = $urandom_range(MIN_SPLIT_CAPACITY, 127);
        hdr = $urandom_range(0, room - dfhg_pkg::FIRST_HDR_BYTES);
        next_room = (room - dfhg_pkg::NEXT_HDR_BYTES) / UNIT_BYTES * UNIT_BYTES;
        first_body = (room - dfhg_pkg::FIRST_HDR_BYTES - hdr) / UNIT_BYTES * UNIT_BYTES;
        lo = room - hdr + 1;
        hi = first_body + (dfhg_pkg::MAX_FRAGMENTS - 1) * next_room;
        if (hi > 2047) hi = 2047;
        if (shape == SHAPE_SHORT && hi > lo + next_room) hi = lo + next_room;
        g.header_length = 7'(hdr);
        g.payload_length = 11'($urandom_range(lo, hi));
        g.frame_capacity = 7'(room);
      end
    endcase
    return g;
  endfunction

  task automatic queue_directed(input int size, input int ofs, input int hlen, input int plen,
                                input int cap);
    datagram_t g;
    g.datagram_size = 11'(size);
    g.start_offset = 11'(ofs);
    g.header_length = 7'(hlen);
    g.payload_length = 11'(plen);
    g.frame_capacity = 7'(cap);
    g.pace = RX_SLOW;
    g.drain = 1'b0;
    datagram_backlog.push_back(g);
  endtask

  // Mostly well-formed split datagrams, with whole frames and unconstrained noise mixed in.
  task automatic queue_random(input int count, input pace_t p, input bit drain_first);
    int     pick;
    shape_t shape;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) shape = SHAPE_ANY;
      else if (pick < 35) shape = SHAPE_WHOLE;
      else if (pick < 55) shape = SHAPE_SHORT;
      else shape = SHAPE_LONG;
      datagram_backlog.push_back(make_datagram(shape, p, drain_first && i == 0));
    end
  endtask

  task automatic flag_mismatch(input string field, input logic [15:0] got,
                               input logic [15:0] expected);
    $display("%0t: frame %0d, %s is %h, expected %h", $time, frames_checked, field, got,
             expected);
    mismatch_count++;
  endtask

  // Input driver: predicts each accepted beat and offers the next datagram.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        split_datagram(in_datagram_size, in_start_offset, in_header_length, in_payload_length,
                       in_frame_capacity);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        offer = datagram_backlog.size() != 0;
        // A draining datagram waits until every owed frame has come out.
        if (offer)
          offer = !(datagram_backlog[0].drain && pending_descriptors.size() != 0)
                  && $urandom_range(0, 99) >= idle_percent(datagram_backlog[0].pace, 1'b0);
        if (offer) begin
          head = datagram_backlog.pop_front();
          in_datagram_size <= head.datagram_size;
          in_start_offset <= head.start_offset;
          in_header_length <= head.header_length;
          in_payload_length <= head.payload_length;
          in_frame_capacity <= head.frame_capacity;
          pace <= head.pace;
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver back-pressure follows the pacing of the datagram last offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= $urandom_range(0, 99) < idle_percent(pace, 1'b1);
    end
  end

  // Output monitor: each accepted beat is checked against the oldest owed frame.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_descriptors.size() == 0) begin
        flag_mismatch("unexpected frame kind", 16'(out_frame_kind), 16'hffff);
      end else begin
        want = pending_descriptors.pop_front();
        if (out_frame_kind !== want.kind)
          flag_mismatch("frame_kind", 16'(out_frame_kind), 16'(want.kind));
        if (out_dispatch_byte !== want.dispatch)
          flag_mismatch("dispatch_byte", 16'(out_dispatch_byte), 16'(want.dispatch));
        if (out_size_low_byte !== want.size_low)
          flag_mismatch("size_low_byte", 16'(out_size_low_byte), 16'(want.size_low));
        if (out_datagram_tag !== want.tag)
          flag_mismatch("datagram_tag", out_datagram_tag, want.tag);
        if (out_offset_units !== want.offset_units)
          flag_mismatch("offset_units", 16'(out_offset_units), 16'(want.offset_units));
        if (out_data_start !== want.data_start)
          flag_mismatch("data_start", 16'(out_data_start), 16'(want.data_start));
        if (out_data_length !== want.data_length)
          flag_mismatch("data_length", 16'(out_data_length), 16'(want.data_length));
        if (out_last !== want.last)
          flag_mismatch("last", 16'(out_last), 16'(want.last));
      end
      frames_checked++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped by the watchdog after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // Directed: field extremes, each frame kind and the corner cases.
    queue_directed(0, 0, 0, 0, 0);
    queue_directed(2047, 2047, 127, 0, 127);
    queue_directed(1, 0, 0, 127, 127);
    queue_directed(2047, 2047, 127, 2047, 127);
    queue_directed(100, 10, 0, 5, 4);
    queue_directed(200, 20, 0, 20, 12);
    queue_directed(2047, 0, 0, 2047, 13);
    queue_directed(2047, 2047, 0, 512, 13);
    queue_directed(1024, 40, 0, 513, 13);
    queue_directed(300, 30, 10, 30, 20);
    queue_directed(700, 16, 16, 10, 20);
    queue_directed(700, 17, 17, 10, 20);
    queue_directed(1280, 0, 0, 2047, 127);
    queue_directed(2000, 127, 127, 1, 127);
    queue_directed(11'h5a5, 11'h2aa, 7'h55, 11'h2aa, 127);
    queue_directed(11'h25a, 11'h555, 7'h2a, 11'h555, 127);
    queue_directed(500, 50, 50, 77, 127);
    queue_directed(500, 50, 50, 78, 127);
    queue_directed(900, 2040, 0, 48, 21);
    // Random traffic under each pacing, draining before the second and third.
    queue_random(50, RX_SLOW, 1'b0);
    queue_random(50, TX_SLOW, 1'b1);
    queue_random(30, NO_IDLE, 1'b1);
    queue_random(30, NO_IDLE, 1'b0);
    total_datagrams = datagram_backlog.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_datagrams) @(posedge clk);
    while (pending_descriptors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d datagrams: %0d whole, %0d split, %0d dropped.", total_datagrams,
             whole_count, split_count, drop_count);
    $display("Checked %0d frames under three pacings; tag counter ended at %h.",
             frames_checked, next_tag);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dfhg_pkg.sv
rtl/dfhg_plan.sv
rtl/dfhg_step.sv
rtl/datagram_fragment_header_generator_core.sv
dv/tb_datagram_fragment_header_generator_core.sv
